// File: hdl/sblt_pkg.sv
`timescale 1ns / 1ps

package sblt_pkg;

    localparam logic [2:0] CMD_INSERT = 3'd0;
    localparam logic [2:0] CMD_APPEND = 3'd1;
    localparam logic [2:0] CMD_CHECK  = 3'd2;
    localparam logic [2:0] CMD_REMOVE = 3'd3;
    localparam logic [2:0] CMD_CLEAR  = 3'd4;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_PRESENT  = 2'd3;

    typedef struct packed {
        logic load;
        logic compare;
        logic execute;
    } dp_ctl_t;

endpackage

// File: hdl/sblt_ctrl.sv
`timescale 1ns / 1ps

module sblt_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    output sblt_pkg::dp_ctl_t ctl
);
    import sblt_pkg::*;

    typedef enum logic [2:0]
    {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_EXEC = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:   state_next = S_EXEC;
            S_EXEC:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign ctl.load    = (state_reg == S_IDLE) && start;
    assign ctl.compare = (state_reg == S_CMP);
    assign ctl.execute = (state_reg == S_EXEC);

    a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("state register not one-hot");
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load |=> ctl.compare)
        else $error("accepted request did not move to compare");
    a_exec: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.compare |=> ctl.execute)
        else $error("compare not followed by execute");

endmodule

// File: hdl/sblt_dp.sv
`timescale 1ns / 1ps

module sblt_dp
#(
    parameter int DEPTH = 32
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  sblt_pkg::dp_ctl_t       ctl,
    input  logic [2:0]              cmd,
    input  logic signed [7:0]       item_value,
    output logic                    done,
    output logic [1:0]              status,
    output logic                    found,
    output logic [5:0]              entry_count
);
    import sblt_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    logic [2:0]        cmd_reg;
    logic signed [7:0] val_reg;
    logic signed [7:0] cells_reg [DEPTH];
    logic signed [7:0] cells_next [DEPTH];
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;

    logic [DEPTH-1:0]  eq_reg;
    logic [DEPTH-1:0]  eq_next;
    logic [DEPTH-1:0]  ge_reg;
    logic [DEPTH-1:0]  ge_next;
    logic              head_le_reg;
    logic              head_le_next;
    logic              tail_le_reg;
    logic              tail_le_next;

    logic              done_reg;
    logic [1:0]        status_reg;
    logic [1:0]        status_next;
    logic              found_reg;
    logic [5:0]        count_out_reg;

    logic [DEPTH-1:0]  shift_mask;
    logic [DEPTH-1:0]  rem_mask;
    logic              do_ins;
    logic              do_rem;
    logic              hit;
    logic              full;

    // per-cell compare against the request value
    always_comb
    begin
        logic acc;
        acc          = 1'b0;
        head_le_next = (count_reg == '0) || (val_reg <= cells_reg[0]);
        for (int i = 0; i < DEPTH; i++)
        begin
            eq_next[i] = ((CW+1)'(i) < {1'b0, count_reg}) && (cells_reg[i] == val_reg);
            ge_next[i] = ((CW+1)'(i + 2) <= {1'b0, count_reg}) && (cells_reg[i] >= val_reg);
            acc = acc | (((CW+1)'(i + 1) == {1'b0, count_reg}) && (cells_reg[i] <= val_reg));
        end
        tail_le_next = acc;
    end

    always_comb
    begin
        logic              acc_ge;
        logic              acc_eq;
        logic [DEPTH-1:0]  tail_mask;
        logic [DEPTH-1:0]  mid_mask;
        logic [DEPTH-1:0]  prev_mask;
        logic signed [7:0] prev_cell [DEPTH];
        logic signed [7:0] next_cell [DEPTH];

        acc_ge = 1'b0;
        acc_eq = 1'b0;
        for (int i = 0; i < DEPTH; i++)
        begin
            acc_ge       = acc_ge | ge_reg[i];
            acc_eq       = acc_eq | eq_reg[i];
            tail_mask[i] = ((CW+1)'(i) >= {1'b0, count_reg});
            mid_mask[i]  = acc_ge || ((CW+1)'(i + 1) >= {1'b0, count_reg});
            rem_mask[i]  = acc_eq;
        end

        hit  = |eq_reg;
        full = ((CW+1)'(DEPTH) <= {1'b0, count_reg});

        do_ins      = 1'b0;
        do_rem      = 1'b0;
        shift_mask  = tail_mask;
        status_next = ST_DONE;
        count_next  = count_reg;

        case (cmd_reg)
            CMD_INSERT:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    do_ins = 1'b1;
                    if (head_le_reg)
                    begin
                        shift_mask = '1;
                    end
                    else if (tail_le_reg)
                    begin
                        shift_mask = tail_mask;
                    end
                    else
                    begin
                        shift_mask = mid_mask;
                    end
                end
            end
            CMD_APPEND:
            begin
                if (hit)
                begin
                    status_next = ST_PRESENT;
                end
                else if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    do_ins = 1'b1;
                end
            end
            CMD_CHECK:
            begin
                status_next = hit ? ST_DONE : ST_NOTFOUND;
            end
            CMD_REMOVE:
            begin
                if (!hit)
                begin
                    status_next = ST_NOTFOUND;
                end
                else
                begin
                    do_rem = 1'b1;
                end
            end
            CMD_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                status_next = ST_DONE;
            end
        endcase

        if (do_ins)
        begin
            count_next = count_reg + CW'(1);
        end
        if (do_rem)
        begin
            count_next = count_reg - CW'(1);
        end

        prev_mask[0] = 1'b0;
        prev_cell[0] = val_reg;
        for (int i = 1; i < DEPTH; i++)
        begin
            prev_mask[i] = shift_mask[i-1];
            prev_cell[i] = cells_reg[i-1];
        end
        next_cell[DEPTH-1] = cells_reg[DEPTH-1];
        for (int i = 0; i < DEPTH - 1; i++)
        begin
            next_cell[i] = cells_reg[i+1];
        end

        for (int i = 0; i < DEPTH; i++)
        begin
            cells_next[i] = cells_reg[i];
            if (do_ins && shift_mask[i])
            begin
                cells_next[i] = prev_mask[i] ? prev_cell[i] : val_reg;
            end
            else if (do_rem && rem_mask[i])
            begin
                cells_next[i] = next_cell[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg <= cmd;
            val_reg <= item_value;
        end
        if (ctl.compare)
        begin
            eq_reg      <= eq_next;
            ge_reg      <= ge_next;
            head_le_reg <= head_le_next;
            tail_le_reg <= tail_le_next;
        end
        if (ctl.execute)
        begin
            cells_reg     <= cells_next;
            status_reg    <= status_next;
            found_reg     <= hit;
            count_out_reg <= 6'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= ctl.execute;
            if (ctl.execute)
            begin
                count_reg <= count_next;
            end
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign found       = found_reg;
    assign entry_count = count_out_reg;

    a_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (CW+1)'(DEPTH) >= {1'b0, count_reg})
        else $error("fill count beyond table depth");
    a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(ctl.execute))
        else $error("result strobe without execute");
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_FULL) |-> ((CW+1)'(DEPTH) == {1'b0, count_reg}))
        else $error("full rejection with room left");

endmodule

// File: hdl/sorted_byte_list_table.sv
`timescale 1ns / 1ps

// Sorted byte list table.
// Request channel: cmd and item_value are taken at a rising edge with start
// high and busy low. Commands: ordered insert, append if absent, check,
// remove first match, clear.
// Result channel: status, found and entry_count are valid for exactly one
// cycle while done is high; the receiver cannot stall the block.
// Each request keeps busy high while the compare state registers the
// parallel compare of every table cell against the value and the execute
// state shifts the cells and updates the fill count. done rises in the
// cycle after the execute state, which is also the first cycle a new
// request can be accepted; no request is taken while one is in flight.
// Reset empties the table (fill count zero); cell contents are not cleared
// and are never used in a compare before being written.
// Full table: inserts and appends of absent values are rejected.
module sorted_byte_list_table
#(
    parameter int DEPTH = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [2:0]        cmd,
    input  logic signed [7:0] item_value,
    output logic              done,
    output logic [1:0]        status,
    output logic              found,
    output logic [5:0]        entry_count
);
    import sblt_pkg::*;

    dp_ctl_t ctl;

    sblt_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .ctl   (ctl)
    );

    sblt_dp #(.DEPTH(DEPTH)) u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .cmd         (cmd),
        .item_value  (item_value),
        .done        (done),
        .status      (status),
        .found       (found),
        .entry_count (entry_count)
    );

endmodule
